>>> rtl/sorted_key_priority_list_assert.svh
// Assertion macros used by the port-level checker of the sorted key priority list.
`ifndef SORTED_KEY_PRIORITY_LIST_ASSERT_SVH
`define SORTED_KEY_PRIORITY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SKPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted key priority list check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SKPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted key priority list check failed");

`endif

>>> rtl/skpl_pkg.sv
// Shared types, constants and pointer helpers of the sorted key priority list.
package skpl_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int ENTRY_W  = KEY_W + TAG_W;

  localparam logic [1:0] REQ_PREPEND = 2'd0;
  localparam logic [1:0] REQ_APPEND  = 2'd1;
  localparam logic [1:0] REQ_SORTED  = 2'd2;
  localparam logic [1:0] REQ_REMOVE  = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJ_EMPTY,
    OP_REJ_FULL,
    OP_PUT_TAIL,
    OP_READ_HEAD,
    OP_READ_LAST,
    OP_WALK_START,
    OP_POP,
    OP_PREPEND,
    OP_APPEND,
    OP_SHIFT,
    OP_PLACE
  } op_e;

  // Status the datapath reports back to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic       empty;
    logic       full;
    logic       left_zero;
    logic       key_gt;
  } skpl_stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    r = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/skpl_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module skpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/skpl_datapath.sv
// Datapath: entry storage, ring pointers, insert walk registers and result registers.
module skpl_datapath import skpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  op_e                     op_i,
  input  logic [1:0]              req_type_i,
  input  logic [TAG_W-1:0]        item_tag_i,
  input  logic signed [KEY_W-1:0] sort_key_i,
  output skpl_stat_t              stat_o,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [TAG_W-1:0]        removed_tag_o,
  output logic signed [KEY_W-1:0] removed_key_o,
  output logic                    now_empty_o
);

  logic [1:0]              req_q, req_d;
  logic [TAG_W-1:0]        tag_q, tag_d;
  logic signed [KEY_W-1:0] key_q, key_d;

  ptr_t head_q, head_d;
  ptr_t tail_q, tail_d;
  cnt_t count_q, count_d;
  ptr_t hole_q, hole_d;
  ptr_t rd_ptr_q, rd_ptr_d;
  cnt_t left_q, left_d;

  logic                    res_valid_q, res_valid_d;
  logic [1:0]              res_status_q, res_status_d;
  logic [TAG_W-1:0]        res_tag_q, res_tag_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  logic                    res_empty_q, res_empty_d;

  logic                    we, re;
  ptr_t                    waddr, raddr;
  logic [ENTRY_W-1:0]      wdata, rdata;
  logic signed [KEY_W-1:0] rd_key, new_key;
  logic [TAG_W-1:0]        rd_tag;
  ptr_t                    last, prehead;
  logic                    fin, fin_pop;
  logic [1:0]              fin_status;

  skpl_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key  = signed'(rdata[ENTRY_W-1:TAG_W]);
  assign rd_tag  = rdata[TAG_W-1:0];
  assign last    = ptr_dec(tail_q);
  assign prehead = ptr_dec(head_q);
  assign new_key = (req_q == REQ_SORTED) ? key_q : '0;

  always_comb begin
    req_d        = req_q;
    tag_d        = tag_q;
    key_d        = key_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    hole_d       = hole_q;
    rd_ptr_d     = rd_ptr_q;
    left_d       = left_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = tail_q;
    raddr        = head_q;
    wdata        = rdata;
    fin          = 1'b0;
    fin_pop      = 1'b0;
    fin_status   = STATUS_DONE;
    unique case (op_i)
      OP_LOAD: begin
        req_d = req_type_i;
        tag_d = item_tag_i;
        key_d = sort_key_i;
      end
      OP_REJ_EMPTY: begin
        fin        = 1'b1;
        fin_status = STATUS_EMPTY;
      end
      OP_REJ_FULL: begin
        fin        = 1'b1;
        fin_status = STATUS_FULL;
      end
      OP_PUT_TAIL: begin
        we      = 1'b1;
        waddr   = tail_q;
        wdata   = {new_key, tag_q};
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
        fin     = 1'b1;
      end
      OP_READ_HEAD: begin
        re    = 1'b1;
        raddr = head_q;
      end
      OP_READ_LAST: begin
        re    = 1'b1;
        raddr = last;
      end
      OP_WALK_START: begin
        re       = 1'b1;
        raddr    = last;
        hole_d   = tail_q;
        rd_ptr_d = ptr_dec(last);
        left_d   = count_q - 1'b1;
      end
      OP_POP: begin
        head_d  = ptr_inc(head_q);
        count_d = count_q - 1'b1;
        fin     = 1'b1;
        fin_pop = 1'b1;
      end
      OP_PREPEND: begin
        we      = 1'b1;
        waddr   = prehead;
        wdata   = {((rd_key == KEY_MIN) ? rd_key : rd_key - 1'b1), tag_q};
        head_d  = prehead;
        count_d = count_q + 1'b1;
        fin     = 1'b1;
      end
      OP_APPEND: begin
        we      = 1'b1;
        waddr   = tail_q;
        wdata   = {((rd_key == KEY_MAX) ? rd_key : rd_key + 1'b1), tag_q};
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
        fin     = 1'b1;
      end
      OP_SHIFT: begin
        // Move the entry just read one slot up; fetch the next one below it while entries are left.
        we     = 1'b1;
        waddr  = hole_q;
        wdata  = rdata;
        hole_d = ptr_dec(hole_q);
        if (left_q != '0) begin
          re       = 1'b1;
          raddr    = rd_ptr_q;
          rd_ptr_d = ptr_dec(rd_ptr_q);
          left_d   = left_q - 1'b1;
        end
      end
      OP_PLACE: begin
        we      = 1'b1;
        waddr   = hole_q;
        wdata   = {key_q, tag_q};
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
        fin     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid_d  = fin;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_key_d    = res_key_q;
    res_empty_d  = res_empty_q;
    if (fin) begin
      res_status_d = fin_status;
      res_tag_d    = fin_pop ? rd_tag : '0;
      res_key_d    = fin_pop ? rd_key : '0;
      res_empty_d  = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    tag_q        <= tag_d;
    key_q        <= key_d;
    hole_q       <= hole_d;
    rd_ptr_q     <= rd_ptr_d;
    left_q       <= left_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_key_q    <= res_key_d;
    res_empty_q  <= res_empty_d;
  end

  assign stat_o.req       = req_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(CAPACITY));
  assign stat_o.left_zero = (left_q == '0);
  assign stat_o.key_gt    = (rd_key > key_q);

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign removed_tag_o  = res_tag_q;
  assign removed_key_o  = res_key_q;
  assign now_empty_o    = res_empty_q;

endmodule

>>> rtl/skpl_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module skpl_ctrl import skpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  skpl_stat_t stat_i,
  output op_e        op_o,
  output logic       busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        priority if (stat_i.req == REQ_REMOVE) begin
          if (stat_i.empty) begin
            op_o = OP_REJ_EMPTY;
          end else begin
            op_o    = OP_READ_HEAD;
            state_d = S_FETCH;
          end
        end else if (stat_i.full) begin
          op_o = OP_REJ_FULL;
        end else if (stat_i.empty) begin
          op_o = OP_PUT_TAIL;
        end else if (stat_i.req == REQ_PREPEND) begin
          op_o    = OP_READ_HEAD;
          state_d = S_FETCH;
        end else if (stat_i.req == REQ_APPEND) begin
          op_o    = OP_READ_LAST;
          state_d = S_FETCH;
        end else begin
          op_o    = OP_WALK_START;
          state_d = S_CMP;
        end
      end
      S_FETCH: begin
        state_d = S_IDLE;
        unique case (stat_i.req)
          REQ_REMOVE:  op_o = OP_POP;
          REQ_PREPEND: op_o = OP_PREPEND;
          REQ_APPEND:  op_o = OP_APPEND;
          default:     op_o = OP_NONE;
        endcase
      end
      S_CMP: begin
        if (stat_i.key_gt) begin
          op_o    = OP_SHIFT;
          state_d = stat_i.left_zero ? S_PLACE : S_CMP;
        end else begin
          op_o    = OP_PLACE;
          state_d = S_IDLE;
        end
      end
      S_PLACE: begin
        op_o    = OP_PLACE;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/sorted_key_priority_list.sv
// Top level of the sorted key priority list: controller plus datapath.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+-----------------------------------------
//   request  | start (in), busy (out)      | req_type_i, item_tag_i, sort_key_i
//   result   | result_valid_o (strobe)     | status_o, removed_tag_o, removed_key_o,
//            |                             | now_empty_o
//
// A request transfer happens on a rising edge with start high and busy low.
// The result strobe is registered from the last step of a request: it follows the execute
// state for a refused request or an insert into an empty list, the fetch state for remove,
// prepend and append, and the compare walk and place step for a sorted insert; the insert
// walk covers one stored entry per cycle through the RAM read port.
// Busy drops with the strobe, as both are set when the controller returns to idle.
// Reset is asynchronous and active low; it empties the list and clears the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle, and a new
// request may be taken in that same cycle.
module sorted_key_priority_list import skpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type_i,
  input  logic [TAG_W-1:0]        item_tag_i,
  input  logic signed [KEY_W-1:0] sort_key_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [TAG_W-1:0]        removed_tag_o,
  output logic signed [KEY_W-1:0] removed_key_o,
  output logic                    now_empty_o
);

  // The entries live in a ring buffer in one RAM, head at head_q and the next free
  // slot at tail_q, so prepend, append and remove never move stored entries.
  // A sorted insert walks down from the tail, shifting each larger key up by one slot,
  // and drops the new entry into the hole once it meets a key that is not larger or has shifted every entry.

  op_e        op;
  skpl_stat_t stat;

  skpl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy)
  );

  skpl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .req_type_i     (req_type_i),
    .item_tag_i     (item_tag_i),
    .sort_key_i     (sort_key_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .removed_tag_o  (removed_tag_o),
    .removed_key_o  (removed_key_o),
    .now_empty_o    (now_empty_o)
  );

endmodule

>>> rtl/skpl_checker.sv
// Port-level checker for the sorted key priority list and its bind statement.
`include "sorted_key_priority_list_assert.svh"

module skpl_checker import skpl_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    result_valid_o,
  input logic [1:0]              status_o,
  input logic [TAG_W-1:0]        removed_tag_o,
  input logic signed [KEY_W-1:0] removed_key_o,
  input logic                    now_empty_o
);

  // A refused request pops nothing.
  `SKPL_ASSERT_IMP(a_refused_no_pop, result_valid_o && status_o != STATUS_DONE, removed_tag_o == '0 && removed_key_o == '0)
  // Remove on an empty list leaves it empty; a full refusal leaves it non-empty.
  `SKPL_ASSERT_IMP(a_empty_status, result_valid_o && status_o == STATUS_EMPTY, now_empty_o)
  `SKPL_ASSERT_IMP(a_full_status, result_valid_o && status_o == STATUS_FULL, !now_empty_o)
  // A request transfer keeps the block busy in the following cycle.
  `SKPL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Results never come in consecutive cycles.
  `SKPL_ASSERT_NEXT(a_strobe_gap, result_valid_o, !result_valid_o)

endmodule

bind sorted_key_priority_list skpl_checker u_checker (.*);
